FILE: design/btxc_pkg.sv
// ----------------------------------------------------------------------------
// btxc_pkg
// Shared types and constants of the binary trie xor count block: sizes,
// action codes, walk states, node entry layout and module-to-module bundles.
// ----------------------------------------------------------------------------
package btxc_pkg;

    // key width and node store size
    localparam int KEY_BITS  = 31;
    localparam int MAX_NODES = 4096;
    localparam int CNT_W     = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int USED_W    = NODE_W + 1;
    localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    // input word action codes
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // walk sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE,
        ST_QUERY,
        ST_DONE
    } walk_state_t;

    // one node: both child links and the counts of both children
    typedef struct packed {
        logic [1:0][NODE_W-1:0] link;
        logic [1:0][CNT_W-1:0]  cnt;
    } node_entry_t;

    // node store access request
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_node;
        logic              wr_en;
        logic [NODE_W-1:0] wr_node;
        node_entry_t       wr_entry;
    } mem_req_t;

    // accepted input word
    typedef struct packed {
        action_t             action;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] goal;
    } item_t;

    // finished result word
    typedef struct packed {
        logic [CNT_W-1:0] above;
        logic [CNT_W-1:0] below;
        logic [CNT_W-1:0] equal;
        logic             full;
    } result_t;

endpackage

FILE: design/btxc_node_store.sv
// ----------------------------------------------------------------------------
// btxc_node_store
// Trie node store: root entry in flops, all other nodes in a synchronous
// memory with one read and one write port and a registered read.
// ----------------------------------------------------------------------------
module btxc_node_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  btxc_pkg::mem_req_t    req,
    output btxc_pkg::node_entry_t rd_entry
);

    btxc_pkg::node_entry_t mem [btxc_pkg::MAX_NODES];
    btxc_pkg::node_entry_t mem_q_reg;
    btxc_pkg::node_entry_t root_reg;
    logic                  rd_root_reg;

    // node memory, nodes are allocated in order so no clearing is needed
    always_ff @(posedge clk)
    begin
        if (req.wr_en && (req.wr_node != '0))
        begin
            mem[req.wr_node] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.rd_node];
        end
    end

    // root entry and read source select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg    <= '0;
            rd_root_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en && (req.wr_node == '0))
            begin
                root_reg <= req.wr_entry;
            end
            if (req.rd_en)
            begin
                rd_root_reg <= (req.rd_node == '0);
            end
        end
    end

    assign rd_entry = rd_root_reg ? root_reg : mem_q_reg;

endmodule

FILE: design/btxc_walker.sv
// ----------------------------------------------------------------------------
// btxc_walker
// Level-by-level trie walk: one node store access per key bit, with a
// read-only capacity check pass when free nodes run low.
// ----------------------------------------------------------------------------
module btxc_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  btxc_pkg::item_t       item,
    input  logic                  take,
    output logic                  busy,
    output logic                  done,
    output btxc_pkg::result_t     result,
    output btxc_pkg::mem_req_t    mem_req,
    input  btxc_pkg::node_entry_t rd_entry
);

    localparam int SUM_W = btxc_pkg::USED_W + 1;

    btxc_pkg::walk_state_t state_reg, state_next;
    logic [btxc_pkg::LVL_W-1:0]    lvl_reg, lvl_next;
    logic [btxc_pkg::NODE_W-1:0]   cur_reg, cur_next;
    logic                          fresh_reg, fresh_next;
    logic [btxc_pkg::USED_W-1:0]   used_reg, used_next;
    btxc_pkg::action_t             act_reg, act_next;
    logic [btxc_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [btxc_pkg::KEY_BITS-1:0] goal_reg, goal_next;
    logic [btxc_pkg::CNT_W-1:0]    up_reg, up_next;
    logic [btxc_pkg::CNT_W-1:0]    down_reg, down_next;
    logic [btxc_pkg::CNT_W-1:0]    eq_reg, eq_next;
    logic                          full_reg, full_next;

    btxc_pkg::node_entry_t         ent;
    btxc_pkg::node_entry_t         upd_entry;
    logic                          last_lvl;
    logic                          kbit;
    logic                          vbit;
    logic                          gbit;
    logic [btxc_pkg::NODE_W-1:0]   upd_link;
    logic                          upd_alloc;
    logic [btxc_pkg::NODE_W-1:0]   upd_nx;
    logic [btxc_pkg::CNT_W-1:0]    delta;
    logic [SUM_W-1:0]              chk_need;
    logic                          chk_full;
    logic                          fast_path;
    logic [btxc_pkg::NODE_W-1:0]   q_sib;
    logic [btxc_pkg::NODE_W-1:0]   q_child;
    logic [btxc_pkg::CNT_W-1:0]    q_sib_cnt;
    logic [btxc_pkg::CNT_W-1:0]    q_acc;

    // current node entry, a freshly allocated node reads as empty
    assign ent      = fresh_reg ? '0 : rd_entry;
    assign last_lvl = (lvl_reg == '0);
    assign kbit     = key_reg[lvl_reg];
    assign gbit     = goal_reg[lvl_reg];
    assign vbit     = key_reg[lvl_reg] ^ goal_reg[lvl_reg];

    // update step: follow or allocate the child on the key bit
    assign upd_link  = ent.link[kbit];
    assign upd_alloc = (upd_link == '0);
    assign upd_nx    = upd_alloc ? used_reg[btxc_pkg::NODE_W-1:0] : upd_link;
    assign delta     = (act_reg == btxc_pkg::ACT_INSERT) ? btxc_pkg::CNT_W'(1) : '1;

    always_comb
    begin
        upd_entry              = ent;
        upd_entry.link[kbit]   = upd_nx;
        upd_entry.cnt[kbit]    = ent.cnt[kbit] + delta;
    end

    // capacity: nodes missing below this level against free nodes
    assign chk_need  = {1'b0, used_reg} + SUM_W'(lvl_reg) + SUM_W'(1);
    assign chk_full  = (chk_need > SUM_W'(btxc_pkg::MAX_NODES));
    assign fast_path = (({1'b0, used_reg} + SUM_W'(btxc_pkg::KEY_BITS))
                        <= SUM_W'(btxc_pkg::MAX_NODES));

    // query step: sibling branch count goes above or below
    assign q_sib     = ent.link[~vbit];
    assign q_child   = ent.link[vbit];
    assign q_sib_cnt = (q_sib != '0) ? ent.cnt[~vbit] : '0;
    assign q_acc     = (gbit ? down_reg : up_reg) + q_sib_cnt;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btxc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (item.action)
                        btxc_pkg::ACT_INSERT,
                        btxc_pkg::ACT_DELETE:
                            state_next = fast_path ? btxc_pkg::ST_UPDATE : btxc_pkg::ST_CHECK;
                        btxc_pkg::ACT_QUERY:
                            state_next = btxc_pkg::ST_QUERY;
                        default:
                            state_next = btxc_pkg::ST_DONE;
                    endcase
                end
            end
            btxc_pkg::ST_CHECK:
            begin
                if (upd_alloc)
                begin
                    state_next = chk_full ? btxc_pkg::ST_DONE : btxc_pkg::ST_UPDATE;
                end
                else if (last_lvl)
                begin
                    state_next = btxc_pkg::ST_UPDATE;
                end
            end
            btxc_pkg::ST_UPDATE:
            begin
                if (last_lvl)
                begin
                    state_next = btxc_pkg::ST_DONE;
                end
            end
            btxc_pkg::ST_QUERY:
            begin
                if ((q_child == '0) || last_lvl)
                begin
                    state_next = btxc_pkg::ST_DONE;
                end
            end
            btxc_pkg::ST_DONE:
            begin
                if (take)
                begin
                    state_next = btxc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btxc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and node store requests
    always_comb
    begin
        lvl_next   = lvl_reg;
        cur_next   = cur_reg;
        fresh_next = fresh_reg;
        used_next  = used_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        goal_next  = goal_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        eq_next    = eq_reg;
        full_next  = full_reg;
        mem_req    = '0;
        case (state_reg)
            btxc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    act_next        = item.action;
                    key_next        = item.key;
                    goal_next       = item.goal;
                    lvl_next        = btxc_pkg::LVL_W'(btxc_pkg::KEY_BITS - 1);
                    cur_next        = '0;
                    fresh_next      = 1'b0;
                    up_next         = '0;
                    down_next       = '0;
                    eq_next         = '0;
                    full_next       = 1'b0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_node = '0;
                end
            end
            btxc_pkg::ST_CHECK:
            begin
                if ((upd_alloc && !chk_full) || (!upd_alloc && last_lvl))
                begin
                    // restart from the root for the real update
                    lvl_next        = btxc_pkg::LVL_W'(btxc_pkg::KEY_BITS - 1);
                    cur_next        = '0;
                    fresh_next      = 1'b0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_node = '0;
                end
                else if (upd_alloc)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    lvl_next        = lvl_reg - 1'b1;
                    cur_next        = upd_link;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_node = upd_link;
                end
            end
            btxc_pkg::ST_UPDATE:
            begin
                mem_req.wr_en    = 1'b1;
                mem_req.wr_node  = cur_reg;
                mem_req.wr_entry = upd_entry;
                used_next        = used_reg + btxc_pkg::USED_W'(upd_alloc);
                if (!last_lvl)
                begin
                    lvl_next        = lvl_reg - 1'b1;
                    cur_next        = upd_nx;
                    fresh_next      = upd_alloc;
                    mem_req.rd_en   = !upd_alloc;
                    mem_req.rd_node = upd_nx;
                end
            end
            btxc_pkg::ST_QUERY:
            begin
                if (gbit)
                begin
                    down_next = q_acc;
                end
                else
                begin
                    up_next = q_acc;
                end
                if (q_child != '0)
                begin
                    if (last_lvl)
                    begin
                        eq_next = ent.cnt[vbit];
                    end
                    else
                    begin
                        lvl_next        = lvl_reg - 1'b1;
                        cur_next        = q_child;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_node = q_child;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btxc_pkg::ST_IDLE;
            lvl_reg   <= '0;
            cur_reg   <= '0;
            fresh_reg <= 1'b0;
            used_reg  <= btxc_pkg::USED_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            cur_reg   <= cur_next;
            fresh_reg <= fresh_next;
            used_reg  <= used_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        key_reg  <= key_next;
        goal_reg <= goal_next;
        up_reg   <= up_next;
        down_reg <= down_next;
        eq_reg   <= eq_next;
        full_reg <= full_next;
    end

    assign busy         = (state_reg != btxc_pkg::ST_IDLE);
    assign done         = (state_reg == btxc_pkg::ST_DONE);
    assign result.above = up_reg;
    assign result.below = down_reg;
    assign result.equal = eq_reg;
    assign result.full  = full_reg;

endmodule

FILE: design/binary_trie_xor_count_top.sv
// ----------------------------------------------------------------------------
// binary_trie_xor_count_top
// Multiset of keys in a binary trie with insert, delete and xor rank query.
// ----------------------------------------------------------------------------
// One word is worked at a time. The cycle in which an insert, delete or
// query is accepted fetches the root, then the walk makes one node store
// access per key bit, then hands the result to the output register, and the
// next word can be accepted in the cycle after that. A query that runs off
// the trie finishes early, and action 3 skips the walk. While the output
// register holds a stalled word, a finished walk waits in its last cycle.
// While fewer than KEY_BITS nodes are free, an insert or delete first makes
// a read-only pass down the key path to see whether the missing nodes fit.
// The node store needs no clearing pass after reset: the root lives in flops
// and other nodes are handed out in order. A finished result waits in the
// output register while the next word is accepted.
module binary_trie_xor_count_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [btxc_pkg::KEY_BITS-1:0]       key,
    input  logic [btxc_pkg::KEY_BITS-1:0]       goal,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [btxc_pkg::CNT_W-1:0]   above_count,
    output logic signed [btxc_pkg::CNT_W-1:0]   below_count,
    output logic signed [btxc_pkg::CNT_W-1:0]   equal_count,
    output logic                                store_full
);

    btxc_pkg::item_t       item;
    btxc_pkg::result_t     result;
    btxc_pkg::mem_req_t    mem_req;
    btxc_pkg::node_entry_t rd_entry;
    btxc_pkg::result_t     out_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  busy;
    logic                  done;
    logic                  slot_free;
    logic                  load;

    assign item.action = btxc_pkg::action_t'(action);
    assign item.key    = key;
    assign item.goal   = goal;

    btxc_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid),
        .item     (item),
        .take     (slot_free),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

    btxc_node_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (mem_req),
        .rd_entry (rd_entry)
    );

    // output word register
    assign slot_free      = !out_valid_reg || !out_stall;
    assign load           = done && slot_free;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign in_stall    = busy;
    assign out_valid   = out_valid_reg;
    assign above_count = $signed(out_data_reg.above);
    assign below_count = $signed(out_data_reg.below);
    assign equal_count = $signed(out_data_reg.equal);
    assign store_full  = out_data_reg.full;

endmodule

FILE: design/btxc_checker.sv
// ----------------------------------------------------------------------------
// btxc_checker
// Port-level checks of the binary trie xor count block, bound to the top.
// ----------------------------------------------------------------------------
module btxc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [btxc_pkg::CNT_W-1:0]   above_count,
    input logic signed [btxc_pkg::CNT_W-1:0]   below_count,
    input logic signed [btxc_pkg::CNT_W-1:0]   equal_count,
    input logic                                store_full
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(above_count)
            && $stable(below_count) && $stable(equal_count) && $stable(store_full))
    else $error("stalled result word changed");

    // one word at a time: the block is busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without a walk");

    // a rejected update carries no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_full |-> above_count == 0 && below_count == 0
            && equal_count == 0)
    else $error("rejected update reports counts");

    // a new result only comes out of a running walk
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a walk");

endmodule

bind binary_trie_xor_count_top btxc_checker u_btxc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .above_count (above_count),
    .below_count (below_count),
    .equal_count (equal_count),
    .store_full  (store_full)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary trie xor count testbench
// Drives insert, delete, query and unused-action words into the trie block
// and checks every result word against a local model of the trie (links,
// signed node counts, node allocation and the store-full rejection). Runs a
// directed part, a long random part over a shared key pool, a backpressure
// stretch, and a fill of the node store up to and past its last free node.
// ----------------------------------------------------------------------------
module testbench;

    localparam int KEY_BITS    = btxc_pkg::KEY_BITS;
    localparam int CNT_W       = btxc_pkg::CNT_W;
    localparam int MAX_NODES   = btxc_pkg::MAX_NODES;
    localparam int POOL_N      = 48;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 2 * (KEY_BITS + 3);
    localparam logic [KEY_BITS-1:0] ALL_ONES = {KEY_BITS{1'b1}};

    // expected result word
    typedef struct packed {
        logic [CNT_W-1:0] above;
        logic [CNT_W-1:0] below;
        logic [CNT_W-1:0] equal;
        logic             full;
    } trie_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    btxc_pkg::action_t          action;
    logic [KEY_BITS-1:0]        key;
    logic [KEY_BITS-1:0]        goal;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [CNT_W-1:0]    above_count;
    logic signed [CNT_W-1:0]    below_count;
    logic signed [CNT_W-1:0]    equal_count;
    logic                       store_full;

    // local trie: child links, node counts and allocation pointer
    int unsigned                trie_link [MAX_NODES][2];
    bit [CNT_W-1:0]             trie_count [MAX_NODES];
    int                         trie_used = 1;

    trie_result_t               expected_q [$];
    trie_result_t               head_result;
    logic [KEY_BITS-1:0]        key_pool [POOL_N];
    int                         mismatches = 0;
    int                         words_checked = 0;
    int                         quiet_cycles = 0;
    bit                         send_idle_en = 1'b1;
    bit                         recv_idle_en = 1'b1;
    bit                         hold_req = 1'b0;

    binary_trie_xor_count_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .goal        (goal),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .above_count (above_count),
        .below_count (below_count),
        .equal_count (equal_count),
        .store_full  (store_full)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [KEY_BITS-1:0] rand_key();
        return KEY_BITS'($urandom);
    endfunction

    // one word through the local trie, returns the expected result
    function automatic trie_result_t trie_step(btxc_pkg::action_t act,
                                               logic [KEY_BITS-1:0] k,
                                               logic [KEY_BITS-1:0] g);
        trie_result_t        res;
        int unsigned         node;
        int unsigned         nxt;
        int unsigned         sib;
        int                  missing;
        logic [CNT_W-1:0]    delta;
        logic [KEY_BITS-1:0] v;
        res = '0;
        case (act)
            btxc_pkg::ACT_INSERT, btxc_pkg::ACT_DELETE:
            begin
                delta = (act == btxc_pkg::ACT_INSERT) ? 32'd1 : 32'hFFFF_FFFF;
                // first pass: how many nodes the path still lacks
                node    = 0;
                missing = 0;
                for (int i = KEY_BITS - 1; i >= 0; i--)
                begin
                    nxt = trie_link[node][k[i]];
                    if (nxt == 0)
                    begin
                        missing = i + 1;
                        break;
                    end
                    node = nxt;
                end
                if (trie_used + missing > MAX_NODES)
                begin
                    res.full = 1'b1;
                end
                else
                begin
                    // second pass: build the path and bump every count on it
                    node = 0;
                    for (int i = KEY_BITS - 1; i >= 0; i--)
                    begin
                        nxt = trie_link[node][k[i]];
                        if (nxt == 0)
                        begin
                            nxt = trie_used;
                            trie_used++;
                            trie_link[nxt][0] = 0;
                            trie_link[nxt][1] = 0;
                            trie_count[nxt]   = '0;
                            trie_link[node][k[i]] = nxt;
                        end
                        node = nxt;
                        trie_count[node] = trie_count[node] + delta;
                    end
                end
            end
            btxc_pkg::ACT_QUERY:
            begin
                // walk key ^ goal, siblings go to above or below by goal bit
                v    = k ^ g;
                node = 0;
                for (int i = KEY_BITS - 1; i >= 0; i--)
                begin
                    sib = trie_link[node][~v[i]];
                    if (sib != 0)
                    begin
                        if (!g[i])
                            res.above = res.above + trie_count[sib];
                        else
                            res.below = res.below + trie_count[sib];
                    end
                    node = trie_link[node][v[i]];
                    if (node == 0)
                        break;
                end
                if (node != 0)
                    res.equal = trie_count[node];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // query goal: hits on pool keys, near misses, extremes or anything
    function automatic logic [KEY_BITS-1:0] pick_goal(logic [KEY_BITS-1:0] k);
        logic [KEY_BITS-1:0] other;
        other = key_pool[$urandom_range(0, POOL_N - 1)];
        case ($urandom_range(0, 4))
            0:       return k ^ other;
            1:       return k ^ other ^ KEY_BITS'($urandom_range(0, 255));
            2:       return '0;
            3:       return ALL_ONES;
            default: return rand_key();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("mismatch at word %0d: %s got %0d expected %0d",
                 words_checked, what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // offer one word, hold it until taken, then maybe idle
    task automatic send_word(btxc_pkg::action_t act, logic [KEY_BITS-1:0] k,
                             logic [KEY_BITS-1:0] g);
        int           gap;
        trie_result_t res_word;
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        goal     <= g;
        do
            @(posedge clk);
        while (in_stall);
        res_word   = trie_step(act, k, g);
        expected_q = {expected_q, res_word};
        if (send_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            action   <= btxc_pkg::action_t'($urandom_range(0, 3));
            key      <= rand_key();
            goal     <= rand_key();
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // sender goes quiet until every expected word is back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly pool keys so that counts build up on shared paths
    task automatic send_random_word();
        int                  pick;
        logic [KEY_BITS-1:0] k;
        pick = $urandom_range(0, 99);
        k    = key_pool[$urandom_range(0, POOL_N - 1)];
        if (pick < 35)
            send_word(btxc_pkg::ACT_INSERT, k, rand_key());
        else if (pick < 55)
            send_word(btxc_pkg::ACT_DELETE, k, rand_key());
        else if (pick < 75)
            send_word(btxc_pkg::ACT_QUERY, k, pick_goal(k));
        else if (pick < 90)
        begin
            k = rand_key();
            send_word(btxc_pkg::ACT_QUERY, k, pick_goal(k));
        end
        else if (pick < 95)
            send_word(pick[0] ? btxc_pkg::ACT_INSERT : btxc_pkg::ACT_DELETE,
                      rand_key(), rand_key());
        else
            send_word(btxc_pkg::ACT_NONE, rand_key(), rand_key());
    endtask

    // extremes, duplicates, absent deletes and the unused action
    task automatic test_directed();
        send_word(btxc_pkg::ACT_QUERY,  '0, '0);
        send_word(btxc_pkg::ACT_INSERT, '0, ALL_ONES);
        send_word(btxc_pkg::ACT_INSERT, ALL_ONES, '0);
        send_word(btxc_pkg::ACT_INSERT, 31'h5555_5555, '0);
        send_word(btxc_pkg::ACT_INSERT, 31'h2AAA_AAAA, '0);
        send_word(btxc_pkg::ACT_INSERT, '0, '0);
        send_word(btxc_pkg::ACT_QUERY,  '0, '0);
        send_word(btxc_pkg::ACT_QUERY,  ALL_ONES, ALL_ONES);
        send_word(btxc_pkg::ACT_QUERY,  '0, ALL_ONES);
        send_word(btxc_pkg::ACT_QUERY,  ALL_ONES, '0);
        send_word(btxc_pkg::ACT_QUERY,  31'h5555_5555, 31'h4000_0000);
        send_word(btxc_pkg::ACT_DELETE, 31'h5555_5555, '0);
        send_word(btxc_pkg::ACT_DELETE, 31'h1234_5678, '0);
        send_word(btxc_pkg::ACT_QUERY,  31'h1234_5678, '0);
        send_word(btxc_pkg::ACT_QUERY,  '0, 31'h1234_5678);
        send_word(btxc_pkg::ACT_NONE,   ALL_ONES, ALL_ONES);
        send_word(btxc_pkg::ACT_DELETE, 31'h1234_5678, ALL_ONES);
        send_word(btxc_pkg::ACT_INSERT, 31'h1234_5679, '0);
        send_word(btxc_pkg::ACT_QUERY,  31'h1234_5678, 31'h0000_0001);
        send_word(btxc_pkg::ACT_QUERY,  ALL_ONES, 31'h3FFF_FFFF);
    endtask

    // random words with idling switched on and off in stretches
    task automatic test_random_mix();
        for (int n = 0; n < 600; n++)
        begin
            if (n % 100 == 0)
            begin
                send_idle_en = ($urandom_range(0, 3) != 0);
                recv_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random_word();
        end
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        send_idle_en = 1'b0;
        hold_req     = 1'b1;
        for (int n = 0; n < 24; n++)
            send_random_word();
        wait_for_results();
        send_idle_en = 1'b1;
    endtask

    // fill the node store, then probe rejection at and past the last node
    task automatic test_store_exhaust();
        int free_nodes;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        while (MAX_NODES - trie_used >= KEY_BITS)
            send_word(btxc_pkg::ACT_INSERT, rand_key(), rand_key());
        free_nodes = MAX_NODES - trie_used;
        if (free_nodes > 0)
        begin
            // one node short, then an exact fit off the all-ones path
            send_word(btxc_pkg::ACT_INSERT,
                      ALL_ONES ^ (KEY_BITS'(1) << free_nodes), '0);
            send_word(btxc_pkg::ACT_INSERT,
                      ALL_ONES ^ (KEY_BITS'(1) << (free_nodes - 1)), '0);
        end
        for (int n = 0; n < 4; n++)
            send_word(btxc_pkg::ACT_INSERT, rand_key(), '0);
        for (int n = 0; n < 3; n++)
            send_word(btxc_pkg::ACT_DELETE, rand_key(), '0);
        send_word(btxc_pkg::ACT_INSERT, ALL_ONES, '0);
        send_word(btxc_pkg::ACT_DELETE, key_pool[2], '0);
        for (int n = 0; n < 6; n++)
            send_word(btxc_pkg::ACT_QUERY, key_pool[$urandom_range(0, POOL_N - 1)],
                      rand_key());
    endtask

    // random words at full rate on a full store
    task automatic test_tail_random();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        for (int n = 0; n < 80; n++)
            send_random_word();
    endtask

    // receiver: long hold on request, otherwise random stall bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (recv_idle_en && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("word with nothing expected", above_count, '0);
            end
            else
            begin
                head_result = expected_q.pop_front();
                if (above_count !== head_result.above)
                    report_mismatch("above_count", above_count, head_result.above);
                if (below_count !== head_result.below)
                    report_mismatch("below_count", below_count, head_result.below);
                if (equal_count !== head_result.equal)
                    report_mismatch("equal_count", equal_count, head_result.equal);
                if (store_full !== head_result.full)
                    report_mismatch("store_full", CNT_W'(store_full),
                                    CNT_W'(head_result.full));
            end
            words_checked++;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = btxc_pkg::ACT_NONE;
        key      = '0;
        goal     = '0;

        // key pool: extremes plus keys clustered under a few prefixes
        key_pool[0] = '0;
        key_pool[1] = ALL_ONES;
        for (int p = 2; p < POOL_N; p++)
        begin
            if (p % 2 == 0)
                key_pool[p] = {rand_key()} & {{(KEY_BITS - 8){1'b1}}, 8'h00};
            else
                key_pool[p] = {rand_key()} & {{(KEY_BITS - 16){1'b1}}, 16'h0000};
            key_pool[p] = (key_pool[p] & ~KEY_BITS'(32'h7E00_0000))
                        | (KEY_BITS'(p % 3) << 25);
            if (p % 2 == 0)
                key_pool[p][7:0] = 8'($urandom);
            else
                key_pool[p][15:0] = 16'($urandom);
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();
        test_store_exhaust();
        test_tail_random();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
